// ----- hdl/bad_pkg.sv -----
package bad_pkg;

    // Pixel and icon pixel width.
    localparam int PIX_W = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Widths of the configuration registers.
    localparam int DIM_CFG_W   = 13;
    localparam int ICOLS_CFG_W = 9;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ICON_ROWS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ICON_COLS  = 3'd3;

    // Default sizes.
    localparam int DEF_MAX_IMAGE_DIM = 4096;
    localparam int DEF_MAX_ICON_COLS = 256;

    // Handshake between a client and the iterative divider.
    typedef struct packed {
        logic start;
        logic ack;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- hdl/bad_ram.sv -----
module bad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read of the entry being written returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/bad_div.sv -----
module bad_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 16,
    parameter int Q_W   = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bad_pkg::t_div_ctl   i_ctl,
    input  logic [NUM_W-1:0]    i_num,
    input  logic [DEN_W-1:0]    i_den,
    output bad_pkg::t_div_stat  o_stat,
    output logic [Q_W-1:0]      o_quot
);

    import bad_pkg::*;

    // Restoring division, one quotient bit per cycle, most significant first.
    // The caller guarantees that the quotient fits in Q_W bits.
    localparam int SH_W  = DEN_W + Q_W;
    localparam int CMP_W = (NUM_W > SH_W) ? NUM_W : SH_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_HOLD
    } t_div_state;

    t_div_state       r_state;
    logic [NUM_W-1:0] r_rem;
    logic [SH_W-1:0]  r_den;
    logic [Q_W-1:0]   r_quot;
    logic [CNT_W-1:0] r_cnt;

    logic [CMP_W-1:0] rem_x;
    logic [CMP_W-1:0] den_x;
    logic             fits;

    always_comb begin
        rem_x = CMP_W'(r_rem);
        den_x = CMP_W'(r_den);
        fits  = (rem_x >= den_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
        end else if (i_ctl.start) begin
            r_state <= D_RUN;
            r_rem   <= i_num;
            r_den   <= SH_W'(i_den) << (Q_W - 1);
            r_quot  <= '0;
            r_cnt   <= CNT_W'(Q_W);
        end else begin
            unique case (r_state)
                D_IDLE: begin
                end
                D_RUN: begin
                    if (fits) begin
                        r_rem <= NUM_W'(rem_x - den_x);
                    end
                    r_quot <= Q_W'({r_quot, fits});
                    r_den  <= r_den >> 1;
                    r_cnt  <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= D_HOLD;
                    end
                end
                D_HOLD: begin
                    if (i_ctl.ack) begin
                        r_state <= D_IDLE;
                    end
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_stat.busy = (r_state != D_IDLE);
    assign o_stat.done = (r_state == D_HOLD);
    assign o_quot      = r_quot;

endmodule

// ----- hdl/bad_setup.sv -----
module bad_setup #(
    parameter int MAX_IMAGE_DIM = bad_pkg::DEF_MAX_IMAGE_DIM,
    parameter int MAX_ICON_COLS = bad_pkg::DEF_MAX_ICON_COLS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic [bad_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [bad_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic                                  o_restart,
    output logic                                  o_ready,
    output logic [$clog2(MAX_IMAGE_DIM + 1)-1:0]  o_rows,
    output logic [$clog2(MAX_IMAGE_DIM + 1)-1:0]  o_cols,
    output logic [$clog2(MAX_IMAGE_DIM + 1)-1:0]  o_irows,
    output logic [$clog2(MAX_IMAGE_DIM + 1)-1:0]  o_icols,
    output logic [$clog2(MAX_IMAGE_DIM + 1)-1:0]  o_bh,
    output logic [$clog2(MAX_IMAGE_DIM + 1)-1:0]  o_bw,
    output logic [2*$clog2(MAX_IMAGE_DIM + 1)-1:0] o_area
);

    import bad_pkg::*;

    localparam int DIM_W  = $clog2(MAX_IMAGE_DIM + 1);
    localparam int AREA_W = 2 * DIM_W;
    localparam int IC_W   = $clog2(MAX_ICON_COLS + 1);
    localparam int CW0    = (DIM_CFG_W > DIM_W + 1) ? DIM_CFG_W : DIM_W + 1;
    localparam int CW     = (CW0 > IC_W) ? CW0 : IC_W;

    typedef enum logic [2:0] {
        S_H_GO,
        S_H_WAIT,
        S_W_GO,
        S_W_WAIT,
        S_MUL,
        S_DONE
    } t_setup_state;

    t_setup_state           r_state;
    logic [DIM_CFG_W-1:0]   r_img_rows;
    logic [DIM_CFG_W-1:0]   r_img_cols;
    logic [DIM_CFG_W-1:0]   r_icon_rows;
    logic [ICOLS_CFG_W-1:0] r_icon_cols;
    logic [DIM_W-1:0]       r_bh;
    logic [DIM_W-1:0]       r_bw;
    logic [AREA_W-1:0]      r_area;

    logic [CW-1:0] rows_w;
    logic [CW-1:0] cols_w;
    logic [CW-1:0] chi_w;
    logic [CW-1:0] irows_w;
    logic [CW-1:0] icols_w;
    logic          cfg_hit;

    t_div_ctl         div_ctl;
    t_div_stat        div_stat;
    logic [DIM_W-1:0] div_num;
    logic [DIM_W-1:0] div_den;
    logic [DIM_W-1:0] div_quot;

    // Clamp the dimensions so that every block holds at least one pixel.
    always_comb begin
        if (r_img_rows == '0) begin
            rows_w = CW'(1);
        end else if (CW'(r_img_rows) > CW'(MAX_IMAGE_DIM)) begin
            rows_w = CW'(MAX_IMAGE_DIM);
        end else begin
            rows_w = CW'(r_img_rows);
        end

        if (r_img_cols == '0) begin
            cols_w = CW'(1);
        end else if (CW'(r_img_cols) > CW'(MAX_IMAGE_DIM)) begin
            cols_w = CW'(MAX_IMAGE_DIM);
        end else begin
            cols_w = CW'(r_img_cols);
        end

        chi_w = (cols_w < CW'(MAX_ICON_COLS)) ? cols_w : CW'(MAX_ICON_COLS);

        if (r_icon_rows == '0) begin
            irows_w = CW'(1);
        end else if (CW'(r_icon_rows) > rows_w) begin
            irows_w = rows_w;
        end else begin
            irows_w = CW'(r_icon_rows);
        end

        if (r_icon_cols == '0) begin
            icols_w = CW'(1);
        end else if (CW'(r_icon_cols) > chi_w) begin
            icols_w = chi_w;
        end else begin
            icols_w = CW'(r_icon_cols);
        end
    end

    always_comb begin
        unique case (i_cfg_index)
            REG_IMAGE_ROWS, REG_IMAGE_COLS, REG_ICON_ROWS, REG_ICON_COLS: begin
                cfg_hit = i_cfg_valid;
            end
            default: begin
                cfg_hit = 1'b0;
            end
        endcase
    end

    always_comb begin
        div_ctl.start = (r_state == S_H_GO) || (r_state == S_W_GO);
        div_ctl.ack   = ((r_state == S_H_WAIT) || (r_state == S_W_WAIT)) && div_stat.done;
        div_num       = (r_state == S_H_GO) ? DIM_W'(rows_w)  : DIM_W'(cols_w);
        div_den       = (r_state == S_H_GO) ? DIM_W'(irows_w) : DIM_W'(icols_w);
    end

    bad_div #(
        .NUM_W (DIM_W),
        .DEN_W (DIM_W),
        .Q_W   (DIM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // Any write to a known register restarts the block size computation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_H_GO;
            r_img_rows  <= DIM_CFG_W'(1);
            r_img_cols  <= DIM_CFG_W'(1);
            r_icon_rows <= DIM_CFG_W'(1);
            r_icon_cols <= ICOLS_CFG_W'(1);
        end else if (cfg_hit) begin
            unique case (i_cfg_index)
                REG_IMAGE_ROWS: r_img_rows  <= DIM_CFG_W'(i_cfg_data);
                REG_IMAGE_COLS: r_img_cols  <= DIM_CFG_W'(i_cfg_data);
                REG_ICON_ROWS:  r_icon_rows <= DIM_CFG_W'(i_cfg_data);
                REG_ICON_COLS:  r_icon_cols <= ICOLS_CFG_W'(i_cfg_data);
                default: begin
                end
            endcase
            r_state <= S_H_GO;
        end else begin
            unique case (r_state)
                S_H_GO: begin
                    r_state <= S_H_WAIT;
                end
                S_H_WAIT: begin
                    if (div_stat.done) begin
                        r_bh    <= div_quot;
                        r_state <= S_W_GO;
                    end
                end
                S_W_GO: begin
                    r_state <= S_W_WAIT;
                end
                S_W_WAIT: begin
                    if (div_stat.done) begin
                        r_bw    <= div_quot;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_area  <= AREA_W'(r_bh) * AREA_W'(r_bw);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                end
                default: begin
                    r_state <= S_H_GO;
                end
            endcase
        end
    end

    assign o_restart = cfg_hit;
    assign o_ready   = (r_state == S_DONE);
    assign o_rows    = DIM_W'(rows_w);
    assign o_cols    = DIM_W'(cols_w);
    assign o_irows   = DIM_W'(irows_w);
    assign o_icols   = DIM_W'(icols_w);
    assign o_bh      = r_bh;
    assign o_bw      = r_bw;
    assign o_area    = r_area;

endmodule

// ----- hdl/block_average_downscaler.sv -----
// Block-average downscaler. Grey 8-bit pixels of one image enter on the slave
// stream in raster order; each output word is the truncated mean of one
// rectangular block, in raster order of the icon, with tlast set on the final
// icon pixel. The block height is image_rows / icon_rows and the block width
// is image_cols / icon_cols, rounded down; rows and columns beyond the last
// full block are consumed and ignored. Register values of zero act as one,
// dimensions are clamped to the maximum image size, and the icon is clamped
// to the image (icon columns also to MAX_ICON_COLS). A write to any known
// register, and the last pixel of an image, restarts the image. After reset
// and after every write to a known register the block works out the block
// size with a bit-serial divider; s_axis_tready stays low meanwhile.
// Per-column block sums live in a synchronous RAM, updated by a two-stage
// read-modify-write with forwarding, so ordinary pixels are taken one per
// cycle while the mean divider is idle. A pixel that completes a block
// starts the mean divider, one quotient bit per cycle, and the next pixel is
// taken only once the mean has moved to the output register. While an icon
// pixel waits on the master side, input keeps flowing until the next block
// completes.
module block_average_downscaler #(
    parameter int MAX_IMAGE_DIM = bad_pkg::DEF_MAX_IMAGE_DIM,
    parameter int MAX_ICON_COLS = bad_pkg::DEF_MAX_ICON_COLS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bad_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bad_pkg::CFG_DATA_W-1:0] i_cfg_data,

    // Source pixels.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bad_pkg::PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel_in

    // Icon pixels.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bad_pkg::PIX_W-1:0]      m_axis_tdata,   // [7:0] icon_pixel
    output logic                           m_axis_tlast    // icon_last
);

    import bad_pkg::*;

    localparam int DIM_W  = $clog2(MAX_IMAGE_DIM + 1);
    localparam int AREA_W = 2 * DIM_W;
    localparam int SUM_W  = AREA_W + PIX_W;
    localparam int COL_W  = (MAX_ICON_COLS > 1) ? $clog2(MAX_ICON_COLS) : 1;

    // Geometry from the setup unit.
    logic              cfg_restart;
    logic              setup_rdy;
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
    logic [DIM_W-1:0]  irows;
    logic [DIM_W-1:0]  icols;
    logic [DIM_W-1:0]  bh;
    logic [DIM_W-1:0]  bw;
    logic [AREA_W-1:0] area;

    // Position of the next source pixel.
    logic [DIM_W-1:0] r_srow, n_srow;
    logic [DIM_W-1:0] r_scol, n_scol;
    logic [DIM_W-1:0] r_rib,  n_rib;
    logic [DIM_W-1:0] r_cib,  n_cib;
    logic [DIM_W-1:0] r_brow, n_brow;
    logic [DIM_W-1:0] r_bcol, n_bcol;

    // One flag per icon column: the RAM entry holds a sum of this image.
    logic [MAX_ICON_COLS-1:0] r_col_vld;

    // Accumulate stage.
    logic             r_s1_vld;
    logic [COL_W-1:0] r_s1_addr;
    logic [PIX_W-1:0] r_s1_pix;
    logic             r_s1_emit;
    logic             r_s1_last;
    logic             r_s1_hit;

    // Forwarding of the word written in the previous cycle.
    logic             r_fwd_vld;
    logic [COL_W-1:0] r_fwd_addr;
    logic [SUM_W-1:0] r_fwd_sum;

    // Output register.
    logic             r_out_vld;
    logic [PIX_W-1:0] r_out_pix;
    logic             r_out_last;
    logic             r_mean_last;

    logic             acc;
    logic             in_block;
    logic             blk_end;
    logic             pix_last;
    logic             eoi;
    logic             restart;
    logic [SUM_W-1:0] ram_rdata;
    logic [SUM_W-1:0] s1_base;
    logic [SUM_W-1:0] s1_sum;

    t_div_ctl         div_ctl;
    t_div_stat        div_stat;
    logic [PIX_W-1:0] div_quot;

    bad_setup #(
        .MAX_IMAGE_DIM (MAX_IMAGE_DIM),
        .MAX_ICON_COLS (MAX_ICON_COLS)
    ) u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_restart   (cfg_restart),
        .o_ready     (setup_rdy),
        .o_rows      (rows),
        .o_cols      (cols),
        .o_irows     (irows),
        .o_icols     (icols),
        .o_bh        (bh),
        .o_bw        (bw),
        .o_area      (area)
    );

    assign o_cfg_ready = 1'b1;

    // An emitting pixel in the accumulate stage or a busy mean divider
    // holds off the next pixel, since only one mean is in flight at a time.
    assign s_axis_tready = setup_rdy && !(r_s1_vld && r_s1_emit) && !div_stat.busy;
    assign acc           = s_axis_tvalid && s_axis_tready;

    // Classify the incoming pixel and step the raster position.
    always_comb begin
        in_block = (r_brow < irows) && (r_bcol < icols);
        blk_end  = (r_rib == bh - DIM_W'(1)) && (r_cib == bw - DIM_W'(1));
        pix_last = (r_brow == irows - DIM_W'(1)) && (r_bcol == icols - DIM_W'(1));

        n_srow = r_srow;
        n_scol = r_scol + DIM_W'(1);
        n_rib  = r_rib;
        n_cib  = r_cib + DIM_W'(1);
        n_brow = r_brow;
        n_bcol = r_bcol;
        eoi    = 1'b0;

        if (n_cib >= bw) begin
            n_cib = '0;
            if (r_bcol < icols) begin
                n_bcol = r_bcol + DIM_W'(1);
            end
        end

        // End of the source row.
        if ({1'b0, r_scol} + (DIM_W + 1)'(1) >= {1'b0, cols}) begin
            n_scol = '0;
            n_cib  = '0;
            n_bcol = '0;
            if ({1'b0, r_rib} + (DIM_W + 1)'(1) >= {1'b0, bh}) begin
                n_rib = '0;
                if (r_brow < irows) begin
                    n_brow = r_brow + DIM_W'(1);
                end
            end else begin
                n_rib = r_rib + DIM_W'(1);
            end
            n_srow = r_srow + DIM_W'(1);
            eoi    = ({1'b0, r_srow} + (DIM_W + 1)'(1) >= {1'b0, rows});
        end
    end

    assign restart = cfg_restart || (acc && eoi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_srow <= '0;
            r_scol <= '0;
            r_rib  <= '0;
            r_cib  <= '0;
            r_brow <= '0;
            r_bcol <= '0;
        end else if (acc) begin
            r_srow <= n_srow;
            r_scol <= n_scol;
            r_rib  <= n_rib;
            r_cib  <= n_cib;
            r_brow <= n_brow;
            r_bcol <= n_bcol;
        end
    end

    // A restart wins over a write from the accumulate stage: that word
    // belongs to the image that has just ended.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_col_vld <= '0;
        end else if (r_s1_vld) begin
            r_col_vld[r_s1_addr] <= !r_s1_emit;
        end
    end

    bad_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_ICON_COLS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld && !r_s1_emit),
        .i_waddr (r_s1_addr),
        .i_wdata (s1_sum),
        .i_raddr (COL_W'(r_bcol)),
        .o_rdata (ram_rdata)
    );

    // The RAM read for this pixel was issued at the edge where its
    // predecessor wrote, so a word written last cycle is taken from the
    // forwarding register. A cleared flag means the sum restarts at zero.
    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_s1_addr)) begin
            s1_base = r_fwd_sum;
        end else if (r_s1_hit) begin
            s1_base = ram_rdata;
        end else begin
            s1_base = '0;
        end
        s1_sum = s1_base + SUM_W'(r_s1_pix);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else begin
            r_s1_vld  <= acc && in_block;
            r_fwd_vld <= r_s1_vld;
        end
        r_s1_addr  <= COL_W'(r_bcol);
        r_s1_pix   <= s_axis_tdata;
        r_s1_emit  <= blk_end;
        r_s1_last  <= pix_last;
        r_s1_hit   <= r_col_vld[COL_W'(r_bcol)];
        r_fwd_addr <= r_s1_addr;
        r_fwd_sum  <= r_s1_emit ? '0 : s1_sum;
    end

    // Mean of a finished block.
    always_comb begin
        div_ctl.start = r_s1_vld && r_s1_emit;
        div_ctl.ack   = div_stat.done && (!r_out_vld || m_axis_tready);
    end

    bad_div #(
        .NUM_W (SUM_W),
        .DEN_W (AREA_W),
        .Q_W   (PIX_W)
    ) u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (s1_sum),
        .i_den   (area),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (div_ctl.ack) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
        if (div_ctl.start) begin
            r_mean_last <= r_s1_last;
        end
        if (div_ctl.ack) begin
            r_out_pix  <= div_quot;
            r_out_last <= r_mean_last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_div_free_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_emit) |-> !div_stat.busy)
        else $error("block completed while the mean divider was busy");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart |=> (r_col_vld == '0))
        else $error("column flags not cleared after image restart");

    a_sum_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_emit) |-> (s1_sum < {area, {PIX_W{1'b0}}}))
        else $error("block sum exceeds the largest possible value");
`endif

endmodule
